FILE: hdl/qbws_pkg.sv
// Package for the quadratic Bezier wall sampler.
// Holds widths, request and tile payload types, controller states and the
// command and status structs shared by the controller and the datapath.
package qbws_pkg;

   localparam int COORD_W   = 16;
   localparam int FRAC      = 16;
   localparam int STEP_W    = FRAC + 1;
   localparam int ONE       = 1 << FRAC;
   localparam int SIZE_W    = 10;
   localparam int KEY_W     = 32;
   localparam int MAX_STEPS = 64;
   localparam int CNT_W     = $clog2(MAX_STEPS);
   localparam int NW        = COORD_W + 2 * FRAC + 1;
   localparam int A_W       = COORD_W + 2;
   localparam int B_W       = COORD_W + 1;
   localparam int HSQ_W     = 2 * STEP_W;
   localparam int LIN_W     = STEP_W + 1 + B_W;
   localparam int QA_W      = HSQ_W + 1 + A_W;

   typedef struct packed {
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
      logic signed [COORD_W-1:0] ctrl_x;
      logic signed [COORD_W-1:0] ctrl_y;
      logic        [SIZE_W-1:0]  thickness;
      logic signed [KEY_W-1:0]   first_key;
      logic        [STEP_W-1:0]  step;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] tile_x;
      logic signed [COORD_W-1:0] tile_y;
      logic        [SIZE_W-1:0]  tile_size;
      logic signed [KEY_W-1:0]   tile_key;
      logic                      last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_INIT,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic load;
      logic setup1;
      logic setup2;
      logic setup3;
      logic step;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic last;
   } status_type;

endpackage

FILE: hdl/quadratic_bezier_wall_sampler_top.sv
// The first tile is registered at the output after ST_MUL1, ST_MUL2, ST_INIT
// and its step in ST_RUN. Throughput: one tile per cycle while rsp_stall does
// not hold the output register; a request with no tiles is found empty in
// ST_MUL1 and returns to ST_IDLE without stepping.
// Reset is synchronous and active high; it clears the controller and tile valid.
// Top level of the quadratic Bezier wall sampler; depends on qbws_pkg.
module quadratic_bezier_wall_sampler_top import qbws_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type    cmd;
   status_type status;

   qbws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   qbws_datapath u_datapath (
      .clock    (clock),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

FILE: hdl/qbws_ctrl.sv
// Controller state machine of the quadratic Bezier wall sampler.
// Sequences setup and tile stepping and owns the tile valid flag.
// Depends on qbws_pkg.
module qbws_ctrl import qbws_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      can_emit;

   assign can_emit = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            if (status.empty) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_MUL2;
            end
         end
         ST_MUL2: begin
            state_in = ST_INIT;
         end
         ST_INIT: begin
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (can_emit && status.last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_MUL1: begin
            cmd.setup1 = 1'b1;
         end
         ST_MUL2: begin
            cmd.setup2 = 1'b1;
         end
         ST_INIT: begin
            cmd.setup3 = 1'b1;
         end
         ST_RUN: begin
            cmd.step = can_emit;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      if (cmd.step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   a_step_free: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (!rsp_valid_ff || !rsp_stall))
      else $error("tile stepped while the output register was held");
   a_load_seq: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == ST_MUL1))
      else $error("accepted request did not start setup");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && status.last) |=> (state_ff == ST_IDLE && rsp_valid_ff))
      else $error("final tile did not end the request");
   a_run_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> !status.empty)
      else $error("stepping a request that has no tiles");
`endif

endmodule

FILE: hdl/qbws_datapath.sv
// Datapath of the quadratic Bezier wall sampler.
// Sets up forward differences with two multiplier stages, then steps the
// curve with exact adds. Depends on qbws_pkg.
module qbws_datapath import qbws_pkg::*; (
   input  logic       clock,
   input  req_type    req_data,
   input  cmd_type    cmd,
   output status_type status,
   output rsp_type    rsp_data
);

   logic signed [COORD_W-1:0] s_x_ff, s_x_in, s_y_ff, s_y_in;
   logic signed [A_W-1:0]     a_x_ff, a_x_in, a_y_ff, a_y_in;
   logic signed [B_W-1:0]     b_x_ff, b_x_in, b_y_ff, b_y_in;
   logic        [STEP_W-1:0]  h_ff, h_in;
   logic        [SIZE_W-1:0]  size_ff, size_in;
   logic        [HSQ_W-1:0]   hsq_ff, hsq_in;
   logic signed [LIN_W-1:0]   lin_x_ff, lin_x_in, lin_y_ff, lin_y_in;
   logic signed [QA_W-1:0]    qa_x_full, qa_y_full;
   logic        [NW-1:0]      qa_x_ff, qa_x_in, qa_y_ff, qa_y_in;
   logic        [NW-1:0]      n_x_ff, n_x_in, n_y_ff, n_y_in;
   logic        [NW-1:0]      d1_x_ff, d1_x_in, d1_y_ff, d1_y_in;
   logic        [NW-1:0]      d2_x_ff, d2_x_in, d2_y_ff, d2_y_in;
   logic        [STEP_W-1:0]  t_ff, t_in;
   logic        [CNT_W-1:0]   k_ff, k_in;
   logic        [KEY_W-1:0]   key_ff, key_in;
   rsp_type                   rsp_ff, rsp_in;

   function automatic logic [COORD_W-1:0] trunc_coord(input logic [NW-1:0] v);
      return v[NW-2:2*FRAC] + COORD_W'(v[NW-1] && (v[2*FRAC-1:0] != '0));
   endfunction

   assign qa_x_full = $signed({1'b0, hsq_ff}) * a_x_ff;
   assign qa_y_full = $signed({1'b0, hsq_ff}) * a_y_ff;

   assign status.empty = h_ff > STEP_W'(ONE);
   assign status.last  = (k_ff == CNT_W'(MAX_STEPS - 1)) ||
                         (({1'b0, t_ff} + {1'b0, h_ff}) > (STEP_W + 1)'(ONE));

   always_comb begin
      s_x_in   = s_x_ff;
      s_y_in   = s_y_ff;
      a_x_in   = a_x_ff;
      a_y_in   = a_y_ff;
      b_x_in   = b_x_ff;
      b_y_in   = b_y_ff;
      h_in     = h_ff;
      size_in  = size_ff;
      hsq_in   = hsq_ff;
      lin_x_in = lin_x_ff;
      lin_y_in = lin_y_ff;
      qa_x_in  = qa_x_ff;
      qa_y_in  = qa_y_ff;
      n_x_in   = n_x_ff;
      n_y_in   = n_y_ff;
      d1_x_in  = d1_x_ff;
      d1_y_in  = d1_y_ff;
      d2_x_in  = d2_x_ff;
      d2_y_in  = d2_y_ff;
      t_in     = t_ff;
      k_in     = k_ff;
      key_in   = key_ff;
      rsp_in   = rsp_ff;
      if (cmd.load) begin
         s_x_in  = req_data.start_x;
         s_y_in  = req_data.start_y;
         a_x_in  = A_W'(req_data.start_x) + A_W'(req_data.end_x) -
                   (A_W'(req_data.ctrl_x) <<< 1);
         a_y_in  = A_W'(req_data.start_y) + A_W'(req_data.end_y) -
                   (A_W'(req_data.ctrl_y) <<< 1);
         b_x_in  = B_W'(req_data.ctrl_x) - B_W'(req_data.start_x);
         b_y_in  = B_W'(req_data.ctrl_y) - B_W'(req_data.start_y);
         h_in    = req_data.step;
         size_in = req_data.thickness;
         key_in  = req_data.first_key;
      end
      if (cmd.setup1) begin
         hsq_in   = h_ff * h_ff;
         lin_x_in = $signed({1'b0, h_ff}) * b_x_ff;
         lin_y_in = $signed({1'b0, h_ff}) * b_y_ff;
      end
      if (cmd.setup2) begin
         qa_x_in = qa_x_full[NW-1:0];
         qa_y_in = qa_y_full[NW-1:0];
      end
      if (cmd.setup3) begin
         n_x_in  = {s_x_ff[COORD_W-1], s_x_ff, {(2*FRAC){1'b0}}};
         n_y_in  = {s_y_ff[COORD_W-1], s_y_ff, {(2*FRAC){1'b0}}};
         d1_x_in = {lin_x_ff[NW-FRAC-2:0], {(FRAC+1){1'b0}}} + qa_x_ff;
         d1_y_in = {lin_y_ff[NW-FRAC-2:0], {(FRAC+1){1'b0}}} + qa_y_ff;
         d2_x_in = {qa_x_ff[NW-2:0], 1'b0};
         d2_y_in = {qa_y_ff[NW-2:0], 1'b0};
         t_in    = h_ff;
         k_in    = '0;
      end
      if (cmd.step) begin
         rsp_in.tile_x    = trunc_coord(n_x_ff);
         rsp_in.tile_y    = trunc_coord(n_y_ff);
         rsp_in.tile_size = size_ff;
         rsp_in.tile_key  = key_ff;
         rsp_in.last      = status.last;
         n_x_in  = n_x_ff + d1_x_ff;
         n_y_in  = n_y_ff + d1_y_ff;
         d1_x_in = d1_x_ff + d2_x_ff;
         d1_y_in = d1_y_ff + d2_y_ff;
         t_in    = t_ff + h_ff;
         k_in    = k_ff + CNT_W'(1);
         key_in  = key_ff + KEY_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      s_x_ff   <= s_x_in;
      s_y_ff   <= s_y_in;
      a_x_ff   <= a_x_in;
      a_y_ff   <= a_y_in;
      b_x_ff   <= b_x_in;
      b_y_ff   <= b_y_in;
      h_ff     <= h_in;
      size_ff  <= size_in;
      hsq_ff   <= hsq_in;
      lin_x_ff <= lin_x_in;
      lin_y_ff <= lin_y_in;
      qa_x_ff  <= qa_x_in;
      qa_y_ff  <= qa_y_in;
      n_x_ff   <= n_x_in;
      n_y_ff   <= n_y_in;
      d1_x_ff  <= d1_x_in;
      d1_y_ff  <= d1_y_in;
      d2_x_ff  <= d2_x_in;
      d2_y_ff  <= d2_y_in;
      t_ff     <= t_in;
      k_ff     <= k_in;
      key_ff   <= key_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule
